FILE: src/haso_pkg.sv
// Shared types and constants for the hall angle and speed observer.
// No dependencies; every other file in src uses it by scoped names.
`timescale 1ns / 1ps

package haso_pkg;

  // Default angle and speed scaling
  localparam int ANGLE_BITS_DEF      = 16;
  localparam int SPEED_FRAC_BITS_DEF = 16;

  // Fixed field widths
  localparam int CODE_W    = 3;
  localparam int TICKS_W   = 16;
  localparam int ELAPSED_W = 32;
  localparam int SPEED_W   = 32;
  localparam int PROD_W    = 64;
  localparam int MIN_EL_W  = 16;
  localparam int RATE_W    = 31;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 31;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ANGLE_OFFSET     = 3'd0,
    CFG_FLIP_DIRECTION   = 3'd1,
    CFG_MIN_ELAPSED      = 3'd2,
    CFG_RATE_LIMIT       = 3'd3,
    CFG_SPEED_THRESHOLD  = 3'd4,
    CFG_PREDICTION_LIMIT = 3'd5
  } cfg_idx_t;

  // Register reset values; angle-valued ones are given for a 16-bit turn
  localparam longint ANGLE_OFFSET_RST16 = 54749;
  localparam longint PRED_LIMIT_RST16   = 13653;
  localparam int     MIN_ELAPSED_RST    = 50;
  localparam int     RATE_LIMIT_RST     = 32'h7FFF_FFFF;
  localparam int     SPEED_THR_RST      = 571;

  // Hall codes, bit0 = A, bit1 = B, bit2 = C
  localparam logic [CODE_W-1:0] HC_ALL_LO = 3'b000;
  localparam logic [CODE_W-1:0] HC_S0     = 3'b001;
  localparam logic [CODE_W-1:0] HC_S1     = 3'b011;
  localparam logic [CODE_W-1:0] HC_S2     = 3'b010;
  localparam logic [CODE_W-1:0] HC_S3     = 3'b110;
  localparam logic [CODE_W-1:0] HC_S4     = 3'b100;
  localparam logic [CODE_W-1:0] HC_S5     = 3'b101;
  localparam logic [CODE_W-1:0] HC_ALL_HI = 3'b111;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MUL  = 2'd1,
    ST_DIV  = 2'd2,
    ST_DONE = 2'd3
  } state_t;

endpackage

FILE: src/haso_if.sv
// Valid/ready channel interfaces for hall samples and position results.
// Depends on haso_pkg for field widths.
`timescale 1ns / 1ps

interface haso_in_if;
  logic                        valid;
  logic                        ready;
  logic [haso_pkg::CODE_W-1:0] hall_code;
  logic [haso_pkg::TICKS_W-1:0] elapsed_ticks;

  modport source (output valid, output hall_code, output elapsed_ticks, input ready);
  modport sink   (input valid, input hall_code, input elapsed_ticks, output ready);
endinterface

interface haso_out_if #(
  parameter int ANGLE_BITS = haso_pkg::ANGLE_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  position_valid;
  logic [ANGLE_BITS-1:0] position;
  logic                  observer_active;

  modport source (output valid, output position_valid, output position,
                  output observer_active, input ready);
  modport sink   (input valid, input position_valid, input position,
                  input observer_active, output ready);
endinterface

FILE: src/hall_angle_speed_observer.sv
// Hall sector angle and speed observer with extrapolated rotor position.
// Depends on haso_pkg and the channel interfaces in haso_if.sv.
`timescale 1ns / 1ps
//
//  channel   dir  handshake          payload
//  in_ch     in   valid/ready        hall_code[2:0], elapsed_ticks[15:0]
//  out_ch    out  valid/ready        position_valid, position[AB-1:0], observer_active
//  cfg_*     in   cfg_we (no wait)   cfg_addr[2:0], cfg_wdata[30:0]
//
//  A valid sample is taken in, runs 32 shift-add steps of the shared 64-bit
//  adder for the travel product, then commits the result. A sector change with
//  enough elapsed time adds ANGLE_BITS+SPEED_FRAC_BITS restoring-divide steps
//  on the same adder. Codes 000 and 111 skip straight to the commit. Reset is
//  synchronous and clears control, observer and config state and output valid,
//  not work or payload registers. A result waits in the output register; the
//  next sample is taken meanwhile and only the commit cycle stalls until out_ch is free.

module hall_angle_speed_observer #(
  parameter int ANGLE_BITS      = haso_pkg::ANGLE_BITS_DEF,
  parameter int SPEED_FRAC_BITS = haso_pkg::SPEED_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  haso_in_if.sink                         in_ch,
  haso_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [haso_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [haso_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AB    = ANGLE_BITS;
  localparam int SFB   = SPEED_FRAC_BITS;
  localparam int DW    = AB + SFB;
  localparam int EW    = haso_pkg::ELAPSED_W;
  localparam int SW    = haso_pkg::SPEED_W;
  localparam int PW    = haso_pkg::PROD_W;
  localparam int MW    = haso_pkg::MIN_EL_W;
  localparam int RW    = haso_pkg::RATE_W;
  localparam int CNT_W = $clog2((DW > EW) ? DW : EW);

  // Sector angles, rounded to the nearest angle unit
  localparam longint TURN = longint'(1) << AB;
  localparam logic [AB-1:0] SA1 = AB'((TURN * 1 + 3) / 6);
  localparam logic [AB-1:0] SA2 = AB'((TURN * 2 + 3) / 6);
  localparam logic [AB-1:0] SA3 = AB'((TURN * 3 + 3) / 6);
  localparam logic [AB-1:0] SA4 = AB'((TURN * 4 + 3) / 6);
  localparam logic [AB-1:0] SA5 = AB'((TURN * 5 + 3) / 6);

  localparam logic [AB-1:0] OFFSET_RST =
    AB'((haso_pkg::ANGLE_OFFSET_RST16 << AB) >> 16);
  localparam logic [AB-1:0] PLIM_RST =
    AB'((haso_pkg::PRED_LIMIT_RST16 << AB) >> 16);

  // Configuration registers
  logic [AB-1:0] offset_r;
  logic          flip_r;
  logic [MW-1:0] min_el_r;
  logic [RW-1:0] rate_r;
  logic [RW-1:0] thr_r;
  logic [AB-1:0] plim_r;

  // Observer state
  logic [AB-1:0] last_r;
  logic [SW-1:0] speed_r;
  logic [EW-1:0] count_r;
  logic          obs_r;

  // Sequencer and work registers
  haso_pkg::state_t state_r, state_nxt;
  logic             invalid_r;
  logic [AB-1:0]    pos_r;
  logic [EW-1:0]    elapsed_r;
  logic             diff_neg_r;
  logic [PW-1:0]    travel_r;
  logic [EW-1:0]    mpl_r;
  logic [DW-1:0]    quo_r;
  logic [EW-1:0]    rem_r;
  logic [CNT_W-1:0] cnt_r;

  // Output register
  logic          out_valid_r;
  logic          out_pv_r;
  logic [AB-1:0] out_pos_r;
  logic          out_obs_r;

  // Control
  logic in_fire, out_free, commit;

  // ---------------------------------------------------------------
  // Sample intake: sector angle, elapsed time, wrapped difference
  logic [haso_pkg::CODE_W-1:0] code;
  logic                        code_bad;
  logic [AB-1:0]               sect_ang, flip_ang, pos_new;
  logic [EW:0]                 el_sum;
  logic [EW-1:0]               el_new;
  logic [AB:0]                 diff_raw, diff_adj, diff_abs;
  logic                        spd_pos, spd_neg;

  assign spd_neg = speed_r[SW-1];
  assign spd_pos = !speed_r[SW-1] && (speed_r != '0);

  always_comb begin
    code     = in_ch.hall_code;
    code_bad = (code == haso_pkg::HC_ALL_LO) || (code == haso_pkg::HC_ALL_HI);
    case (code)
      haso_pkg::HC_S1: sect_ang = SA1;
      haso_pkg::HC_S2: sect_ang = SA2;
      haso_pkg::HC_S3: sect_ang = SA3;
      haso_pkg::HC_S4: sect_ang = SA4;
      haso_pkg::HC_S5: sect_ang = SA5;
      default:         sect_ang = '0;
    endcase
    flip_ang = flip_r ? (-sect_ang) : sect_ang;
    pos_new  = flip_ang + offset_r;

    // saturating elapsed count
    el_sum = {1'b0, count_r} + (EW + 1)'(in_ch.elapsed_ticks);
    el_new = el_sum[EW] ? '1 : el_sum[EW-1:0];

    // one turn added or removed flips the top bit of the AB+1 bit difference
    diff_raw = {1'b0, pos_new} - {1'b0, last_r};
    if ((spd_pos && diff_raw[AB]) || (spd_neg && !diff_raw[AB] && diff_raw != '0)) begin
      diff_adj = {~diff_raw[AB], diff_raw[AB-1:0]};
    end else begin
      diff_adj = diff_raw;
    end
    diff_abs = diff_adj[AB] ? (-diff_adj) : diff_adj;
  end

  // ---------------------------------------------------------------
  // Shared adder: shift-add multiply and restoring divide
  logic [PW-1:0] op_a, op_b, add_sum;
  logic          add_cin;
  logic [EW:0]   r_sh;
  logic          div_ge;

  always_comb begin
    r_sh    = {rem_r, quo_r[DW-1]};
    op_a    = '0;
    op_b    = '0;
    add_cin = 1'b0;
    case (state_r)
      haso_pkg::ST_MUL: begin
        op_a = {travel_r[PW-2:0], 1'b0};
        op_b = mpl_r[EW-1] ? {{(PW - SW){speed_r[SW-1]}}, speed_r} : '0;
      end
      haso_pkg::ST_DIV: begin
        op_a    = {{(PW - EW - 1){1'b0}}, r_sh};
        op_b    = ~{{(PW - EW){1'b0}}, elapsed_r};
        add_cin = 1'b1;
      end
      default: begin
        op_a = '0;
      end
    endcase
    add_sum = op_a + op_b + PW'(add_cin);
    div_ge  = !add_sum[PW-1];
  end

  // ---------------------------------------------------------------
  // Commit decisions, all from registered values
  logic             change, upd_try, q_ok, accepted, thr_hit;
  logic [PW-1:0]    lim, neg_lim, q_w;
  logic             ovr_pos, ovr_neg, obs_new;
  logic [SW:0]      sp_x, q_x, spd_sum;
  logic [AB-1:0]    predicted, pos_out;

  always_comb begin
    change   = (pos_r != last_r);
    upd_try  = change && (elapsed_r > EW'(min_el_r));
    q_w      = {{(PW - DW){1'b0}}, quo_r};
    q_ok     = q_w < PW'(rate_r);
    accepted = upd_try && q_ok;
    thr_hit  = $signed({speed_r[SW-1], speed_r}) > $signed({2'b00, thr_r});

    lim     = PW'(plim_r) << SFB;
    neg_lim = -lim;
    ovr_pos = $signed(travel_r) > $signed(lim);
    ovr_neg = $signed(travel_r) < $signed(neg_lim);

    if (change) begin
      obs_new = obs_r || thr_hit;
    end else begin
      obs_new = obs_r && !((spd_pos && ovr_pos) || (spd_neg && ovr_neg));
    end

    // average of old and new estimate, rounded toward minus infinity
    sp_x    = {speed_r[SW-1], speed_r};
    q_x     = q_w[SW:0];
    spd_sum = diff_neg_r ? (sp_x - q_x) : (sp_x + q_x);

    predicted = last_r + travel_r[SFB +: AB];
    pos_out   = obs_new ? predicted : pos_r;
  end

  // ---------------------------------------------------------------
  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      haso_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = code_bad ? haso_pkg::ST_DONE : haso_pkg::ST_MUL;
        end
      end
      haso_pkg::ST_MUL: begin
        if (cnt_r == '0) begin
          state_nxt = upd_try ? haso_pkg::ST_DIV : haso_pkg::ST_DONE;
        end
      end
      haso_pkg::ST_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = haso_pkg::ST_DONE;
        end
      end
      haso_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = haso_pkg::ST_IDLE;
        end
      end
      default: state_nxt = haso_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ch.ready = (state_r == haso_pkg::ST_IDLE);
    out_free    = !out_valid_r || out_ch.ready;
    commit      = (state_r == haso_pkg::ST_DONE) && out_free;
    in_fire     = in_ch.valid && in_ch.ready;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.position_valid  = out_pv_r;
  assign out_ch.position        = out_pos_r;
  assign out_ch.observer_active = out_obs_r;

  // ---------------------------------------------------------------
  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OFFSET_RST;
      flip_r   <= 1'b0;
      min_el_r <= MW'(haso_pkg::MIN_ELAPSED_RST);
      rate_r   <= RW'(haso_pkg::RATE_LIMIT_RST);
      thr_r    <= RW'(haso_pkg::SPEED_THR_RST);
      plim_r   <= PLIM_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        haso_pkg::CFG_ANGLE_OFFSET:     offset_r <= cfg_wdata[AB-1:0];
        haso_pkg::CFG_FLIP_DIRECTION:   flip_r   <= cfg_wdata[0];
        haso_pkg::CFG_MIN_ELAPSED:      min_el_r <= cfg_wdata[MW-1:0];
        haso_pkg::CFG_RATE_LIMIT:       rate_r   <= cfg_wdata[RW-1:0];
        haso_pkg::CFG_SPEED_THRESHOLD:  thr_r    <= cfg_wdata[RW-1:0];
        haso_pkg::CFG_PREDICTION_LIMIT: plim_r   <= cfg_wdata[AB-1:0];
        default: ;
      endcase
    end
  end

  // Control state, observer state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= haso_pkg::ST_IDLE;
      last_r      <= '0;
      speed_r     <= '0;
      count_r     <= '0;
      obs_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
        if (!invalid_r) begin
          obs_r <= obs_new;
          if (accepted) begin
            speed_r <= spd_sum[SW:1];
            last_r  <= pos_r;
            count_r <= '0;
          end else begin
            count_r <= elapsed_r;
          end
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Work registers: load on intake, then step the shared adder
  always_ff @(posedge clk) begin
    if (in_fire) begin
      invalid_r  <= code_bad;
      pos_r      <= pos_new;
      elapsed_r  <= el_new;
      mpl_r      <= el_new;
      travel_r   <= '0;
      quo_r      <= {diff_abs[AB-1:0], {SFB{1'b0}}};
      rem_r      <= '0;
      diff_neg_r <= diff_adj[AB];
      cnt_r      <= CNT_W'(EW - 1);
    end else begin
      case (state_r)
        haso_pkg::ST_MUL: begin
          travel_r <= add_sum;
          mpl_r    <= {mpl_r[EW-2:0], 1'b0};
          cnt_r    <= (cnt_r == '0) ? CNT_W'(DW - 1) : (cnt_r - 1'b1);
        end
        haso_pkg::ST_DIV: begin
          rem_r <= div_ge ? add_sum[EW-1:0] : r_sh[EW-1:0];
          quo_r <= {quo_r[DW-2:0], div_ge};
          cnt_r <= cnt_r - 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (commit) begin
      out_pv_r  <= !invalid_r;
      out_pos_r <= invalid_r ? '0 : pos_out;
      out_obs_r <= invalid_r ? 1'b0 : obs_new;
    end
  end

  // ---------------------------------------------------------------
  // Assertions
  a_sector_move_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(last_r) |-> (count_r == '0))
    else $error("sector angle moved without clearing the elapsed count");

  a_div_only_on_change: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == haso_pkg::ST_DIV) |-> (pos_r != last_r))
    else $error("divider running without a sector change");

  a_invalid_skips_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == haso_pkg::ST_MUL || state_r == haso_pkg::ST_DIV) |-> !invalid_r)
    else $error("invalid hall code entered the arithmetic steps");

  a_observer_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.observer_active) |-> out_ch.position_valid)
    else $error("observer flagged on an invalid position");

  a_intake_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != haso_pkg::ST_IDLE))
    else $error("sequencer stayed idle after a sample transfer");

endmodule
